// ===== src/aga_pkg.sv =====
// Shared types and codes for the affine-gap local aligner.
`timescale 1ns / 1ps
package aga_pkg;

  localparam int GENOME_MAX_DEF = 1024;
  localparam int READ_MAX_DEF   = 256;

  // Command codes
  localparam logic [1:0] CMD_GENOME = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  // Back codes held in the pointer matrix, one per state
  localparam logic [2:0] CODE_STOP = 3'd0;
  localparam logic [2:0] CODE_N_N  = 3'd1;
  localparam logic [2:0] CODE_N_D  = 3'd2;
  localparam logic [2:0] CODE_W_D  = 3'd3;
  localparam logic [2:0] CODE_W_W  = 3'd4;
  localparam logic [2:0] CODE_D_N  = 3'd5;
  localparam logic [2:0] CODE_D_D  = 3'd6;
  localparam logic [2:0] CODE_D_W  = 3'd7;

  // Register indexes
  localparam logic [2:0] REG_MATCH    = 3'd0;
  localparam logic [2:0] REG_MISMATCH = 3'd1;
  localparam logic [2:0] REG_G_OPEN   = 3'd2;
  localparam logic [2:0] REG_G_EXTEND = 3'd3;
  localparam logic [2:0] REG_R_OPEN   = 3'd4;
  localparam logic [2:0] REG_R_EXTEND = 3'd5;
  localparam logic [2:0] REG_TIE      = 3'd6;

  // Lanes of a score triple
  localparam int ST_D = 0;
  localparam int ST_N = 1;
  localparam int ST_W = 2;

  typedef struct packed {
    logic [7:0]        match_score;
    logic signed [8:0] mismatch_score;
    logic [7:0]        genome_gap_open;
    logic [7:0]        genome_gap_extend;
    logic [7:0]        read_gap_open;
    logic [7:0]        read_gap_extend;
    logic              tie_order;
  } cfg_t;

  function automatic int clog2_min1(input int v);
    int r;
    r = $clog2(v);
    return (r < 1) ? 1 : r;
  endfunction

endpackage

// ===== src/aga_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module aga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/aga_cell.sv =====
// Cell unit: diagonal, north and west scores with back codes for one matrix cell.
`timescale 1ns / 1ps
module aga_cell #(
  parameter int SW = 16
) (
  input  aga_pkg::cfg_t             cfg,
  input  logic                      eq,
  input  logic [2:0][SW-1:0]        nw,
  input  logic [2:0][SW-1:0]        n,
  input  logic [2:0][SW-1:0]        w,
  output logic [2:0][SW-1:0]        cur,
  output logic [8:0]                ptr
);
  import aga_pkg::*;

  localparam int CW = SW + 2;

  logic signed [CW-1:0] ms, r_open, r_ext, g_open, g_ext;
  logic signed [CW-1:0] cd, cn, cw_, nd_c, nn_c, wd_c, ww_c;
  logic signed [CW-1:0] td, tn, tw;
  logic [2:0] bd, bn, bw;

  function automatic logic signed [CW-1:0] ext(input logic [SW-1:0] v);
    return $signed({2'b00, v});
  endfunction

  function automatic logic signed [CW-1:0] ext8(input logic [7:0] v);
    return $signed({{(CW-8){1'b0}}, v});
  endfunction

  assign ms     = eq ? ext8(cfg.match_score) : CW'(cfg.mismatch_score);
  assign r_open = ext8(cfg.read_gap_open);
  assign r_ext  = ext8(cfg.read_gap_extend);
  assign g_open = ext8(cfg.genome_gap_open);
  assign g_ext  = ext8(cfg.genome_gap_extend);

  assign cd   = ext(nw[ST_D]) + ms;
  assign cn   = ext(nw[ST_N]) + ms;
  assign cw_  = ext(nw[ST_W]) + ms;
  assign nd_c = ext(n[ST_D]) - r_open - r_ext;
  assign nn_c = ext(n[ST_N]) - r_ext;
  assign wd_c = ext(w[ST_D]) - g_open - g_ext;
  assign ww_c = ext(w[ST_W]) - g_ext;

  always_comb begin
    if (!cfg.tie_order) begin
      td = cd; bd = CODE_D_D;
      if (cn > td) begin td = cn; bd = CODE_D_N; end
      if (cw_ > td) begin td = cw_; bd = CODE_D_W; end
      tn = nd_c; bn = CODE_N_D;
      if (nn_c > tn) begin tn = nn_c; bn = CODE_N_N; end
      tw = wd_c; bw = CODE_W_D;
      if (ww_c > tw) begin tw = ww_c; bw = CODE_W_W; end
    end else begin
      td = cw_; bd = CODE_D_W;
      if (cn > td) begin td = cn; bd = CODE_D_N; end
      if (cd > td) begin td = cd; bd = CODE_D_D; end
      tn = nn_c; bn = CODE_N_N;
      if (nd_c > tn) begin tn = nd_c; bn = CODE_N_D; end
      tw = ww_c; bw = CODE_W_W;
      if (wd_c > tw) begin tw = wd_c; bw = CODE_W_D; end
    end
    // clamp at zero; a clamped state ends a path
    if (td <= 0) begin td = '0; bd = CODE_STOP; end
    if (tn <= 0) begin tn = '0; bn = CODE_STOP; end
    if (tw <= 0) begin tw = '0; bw = CODE_STOP; end
    cur[ST_D] = td[SW-1:0];
    cur[ST_N] = tn[SW-1:0];
    cur[ST_W] = tw[SW-1:0];
    ptr = {bw, bn, bd};
  end
endmodule

// ===== src/affine_gap_local_align_top.sv =====
// Top level of the affine-gap local aligner: stores, fill sequencer and traceback.
// A load writes its base into a store; busy stays low. A run steps through S_ROW per
// row, S_CALC and S_UPD per filled cell, and on a hit S_TBA, then S_TBB and S_TBC per
// traceback step; the shared cell unit and its row memory set this. busy is high all run.
// The result is shown for one cycle on done; the receiver cannot stall.
// rst (synchronous) returns to idle and restores the register defaults; stores keep data.
`timescale 1ns / 1ps
module affine_gap_local_align_top #(
  parameter int GENOME_MAX = aga_pkg::GENOME_MAX_DEF,
  parameter int READ_MAX   = aga_pkg::READ_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [9:0]  position,
  input  logic [3:0]  base,
  input  logic [10:0] genome_length,
  input  logic [8:0]  read_length,
  input  logic [15:0] target_score,
  input  logic [31:0] genome_offset,
  output logic        done,
  output logic [15:0] score,
  output logic        found,
  output logic [7:0]  end_read,
  output logic [9:0]  end_genome,
  output logic [7:0]  start_read,
  output logic [31:0] start_genome,
  output logic [8:0]  match_count,
  output logic [8:0]  mismatch_count,
  output logic [9:0]  insertion_count,
  output logic [8:0]  deletion_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import aga_pkg::*;

  localparam int GW  = clog2_min1(GENOME_MAX);
  localparam int IW  = clog2_min1(READ_MAX);
  localparam int GLW = clog2_min1(GENOME_MAX + 1);
  localparam int RLW = clog2_min1(READ_MAX + 1);
  localparam int RAW = clog2_min1(GENOME_MAX + 1);
  localparam int SW  = clog2_min1(READ_MAX * 255 + 1);
  localparam int BW  = (SW > 16) ? SW : 16;
  localparam int PW  = IW + GW;
  localparam int PDEPTH = READ_MAX * (2 ** GW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_TBA  = 3'd4;
  localparam logic [2:0] S_TBB  = 3'd5;
  localparam logic [2:0] S_TBC  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;
  cfg_t       cfg;

  logic [GLW-1:0] glen;
  logic [RLW-1:0] rlen;
  logic [15:0]    target;
  logic [31:0]    goff;
  logic [IW-1:0]  i;
  logic [GW-1:0]  j;
  logic           first_row;
  logic [2:0][SW-1:0] nw_v, w_v, cell_out, prev_n;
  logic [8:0]     ptr_q, ptr_new;
  logic [BW-1:0]  best, best_next;
  logic signed [IW:0] ti, ti_next;
  logic signed [GW:0] tj, tj_next;
  logic [2:0]     code, from_init, code_next;
  logic [IW-1:0]  rs;
  logic [GW-1:0]  gs;
  logic           is_del, is_ins, last_j, last_i, hit_now, run_cmd;
  logic [GLW-1:0] glen_sat;
  logic [RLW-1:0] rlen_sat;

  // store ports
  logic           g_we, g_re, r_we, r_re, row_re, p_we, p_re;
  logic [GW-1:0]  g_raddr;
  logic [IW-1:0]  r_raddr;
  logic [3:0]     g_dout, r_dout;
  logic [RAW-1:0] row_raddr, row_waddr;
  logic [3*SW-1:0] row_dout;
  logic [PW-1:0]  p_raddr;
  logic [8:0]     p_dout;

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign cfg_ready = 1'b1;
  assign run_cmd   = start && !busy && (cmd == CMD_RUN);

  assign glen_sat = (32'(genome_length) > 32'(GENOME_MAX)) ? GLW'(GENOME_MAX)
                                                           : GLW'(genome_length);
  assign rlen_sat = (32'(read_length) > 32'(READ_MAX)) ? RLW'(READ_MAX)
                                                       : RLW'(read_length);

  assign g_we = start && !busy && (cmd == CMD_GENOME) && (32'(position) < 32'(GENOME_MAX));
  assign r_we = start && !busy && (cmd == CMD_READ) && (32'(position) < 32'(READ_MAX));

  assign last_j = (32'(j) + 32'd1 == 32'(glen));
  assign last_i = (32'(i) + 32'd1 == 32'(rlen));

  // first row sees an all-zero row above it
  assign prev_n = first_row ? '0 : row_dout;

  aga_cell #(.SW(SW)) u_cell (
    .cfg (cfg),
    .eq  (g_dout == r_dout),
    .nw  (nw_v),
    .n   (prev_n),
    .w   (w_v),
    .cur (cell_out),
    .ptr (ptr_new)
  );

  always_comb begin
    best_next = best;
    if (BW'(w_v[ST_D]) > best_next) best_next = BW'(w_v[ST_D]);
    if (BW'(w_v[ST_N]) > best_next) best_next = BW'(w_v[ST_N]);
    if (BW'(w_v[ST_W]) > best_next) best_next = BW'(w_v[ST_W]);
    hit_now = (best_next == BW'(target));
  end

  // start code at the end cell: diagonal, then west, then north on strict gain
  always_comb begin
    logic [SW-1:0] fs;
    fs = w_v[ST_D];
    from_init = ptr_q[2:0];
    if (w_v[ST_W] > fs) begin
      from_init = ptr_q[8:6];
      fs = w_v[ST_W];
    end
    if (w_v[ST_N] > fs) from_init = ptr_q[5:3];
  end

  // traceback move
  assign is_del  = (code == CODE_N_N) || (code == CODE_N_D);
  assign is_ins  = (code == CODE_W_W) || (code == CODE_W_D);
  assign ti_next = is_ins ? ti : ti - 1'b1;
  assign tj_next = is_del ? tj : tj - 1'b1;

  always_comb begin
    if (ti[IW] || tj[GW]) begin
      code_next = CODE_STOP;
    end else begin
      case (code)
        CODE_N_N, CODE_D_N: code_next = p_dout[5:3];
        CODE_W_W, CODE_D_W: code_next = p_dout[8:6];
        default:            code_next = p_dout[2:0];
      endcase
    end
  end

  // read address selection
  always_comb begin
    g_re      = 1'b0;
    r_re      = 1'b0;
    row_re    = 1'b0;
    p_re      = 1'b0;
    g_raddr   = tj[GW-1:0];
    r_raddr   = ti[IW-1:0];
    row_raddr = RAW'(1);
    p_raddr   = {ti_next[IW-1:0], tj_next[GW-1:0]};
    unique case (state)
      S_ROW: begin
        g_re = 1'b1; r_re = 1'b1; row_re = 1'b1;
        g_raddr = '0;
        r_raddr = i;
      end
      S_UPD: begin
        g_re = !last_j;
        row_re = !last_j;
        g_raddr = GW'(32'(j) + 32'd1);
        row_raddr = RAW'(32'(j) + 32'd2);
      end
      S_TBA, S_TBC: begin
        g_re = 1'b1; r_re = 1'b1;
      end
      S_TBB: begin
        p_re = (code != CODE_STOP) && !ti_next[IW] && !tj_next[GW];
      end
      S_IDLE, S_CALC, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign row_waddr = RAW'(32'(j) + 32'd1);
  assign p_we      = (state == S_UPD);

  aga_ram #(.WIDTH(4), .DEPTH(GENOME_MAX), .AW(GW)) u_genome (
    .clk(clk), .we(g_we), .waddr(GW'(position)), .wdata(base),
    .re(g_re), .raddr(g_raddr), .rdata(g_dout)
  );

  aga_ram #(.WIDTH(4), .DEPTH(READ_MAX), .AW(IW)) u_read (
    .clk(clk), .we(r_we), .waddr(IW'(position)), .wdata(base),
    .re(r_re), .raddr(r_raddr), .rdata(r_dout)
  );

  aga_ram #(.WIDTH(3 * SW), .DEPTH(GENOME_MAX + 1), .AW(RAW)) u_row (
    .clk(clk), .we(p_we), .waddr(row_waddr), .wdata(w_v),
    .re(row_re), .raddr(row_raddr), .rdata(row_dout)
  );

  aga_ram #(.WIDTH(9), .DEPTH(PDEPTH), .AW(PW)) u_ptr (
    .clk(clk), .we(p_we), .waddr({i, j}), .wdata(ptr_q),
    .re(p_re), .raddr(p_raddr), .rdata(p_dout)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_score       <= 8'd10;
      cfg.mismatch_score    <= -9'sd15;
      cfg.genome_gap_open   <= 8'd40;
      cfg.genome_gap_extend <= 8'd7;
      cfg.read_gap_open     <= 8'd40;
      cfg.read_gap_extend   <= 8'd7;
      cfg.tie_order         <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MATCH:    cfg.match_score       <= cfg_data[7:0];
        REG_MISMATCH: cfg.mismatch_score    <= $signed(cfg_data);
        REG_G_OPEN:   cfg.genome_gap_open   <= cfg_data[7:0];
        REG_G_EXTEND: cfg.genome_gap_extend <= cfg_data[7:0];
        REG_R_OPEN:   cfg.read_gap_open     <= cfg_data[7:0];
        REG_R_EXTEND: cfg.read_gap_extend   <= cfg_data[7:0];
        REG_TIE:      cfg.tie_order         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (run_cmd) begin
            glen   <= glen_sat;
            rlen   <= rlen_sat;
            target <= target_score;
            goff   <= genome_offset;
            i      <= '0;
            first_row <= 1'b1;
            best   <= '0;
            score  <= '0;
            found  <= 1'b0;
            end_read <= '0;
            end_genome <= '0;
            start_read <= '0;
            start_genome <= '0;
            match_count <= '0;
            mismatch_count <= '0;
            insertion_count <= '0;
            deletion_count <= '0;
            if (glen_sat == '0 || rlen_sat == '0) state <= S_DONE;
            else state <= S_ROW;
          end
        end
        S_ROW: begin
          j     <= '0;
          nw_v  <= '0;
          w_v   <= '0;
          state <= S_CALC;
        end
        S_CALC: begin
          w_v   <= cell_out;
          ptr_q <= ptr_new;
          nw_v  <= prev_n;
          state <= S_UPD;
        end
        S_UPD: begin
          best <= best_next;
          if (hit_now) begin
            end_read   <= 8'(i);
            end_genome <= 10'(j);
            ti   <= $signed({1'b0, i});
            tj   <= $signed({1'b0, j});
            code <= from_init;
            rs   <= '0;
            gs   <= '0;
            state <= S_TBA;
          end else if (last_j) begin
            if (last_i) begin
              score <= best_next[15:0];
              state <= S_DONE;
            end else begin
              i <= i + 1'b1;
              first_row <= 1'b0;
              state <= S_ROW;
            end
          end else begin
            j <= j + 1'b1;
            state <= S_CALC;
          end
        end
        S_TBA: begin
          state <= S_TBB;
        end
        S_TBB: begin
          if (code == CODE_STOP) begin
            score <= best[15:0];
            found <= 1'b1;
            start_read <= 8'(rs);
            start_genome <= 32'(gs) + goff;
            state <= S_DONE;
          end else begin
            if (is_del) begin
              deletion_count <= deletion_count + 1'b1;
              rs <= ti[IW-1:0];
            end else if (is_ins) begin
              insertion_count <= insertion_count + 1'b1;
              gs <= tj[GW-1:0];
            end else begin
              if (g_dout == r_dout) match_count <= match_count + 1'b1;
              else mismatch_count <= mismatch_count + 1'b1;
              rs <= ti[IW-1:0];
              gs <= tj[GW-1:0];
            end
            ti <= ti_next;
            tj <= tj_next;
            state <= S_TBC;
          end
        end
        S_TBC: begin
          code  <= code_next;
          state <= S_TBB;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== src/aga_checker.sv =====
// Port-level checks on the aligner, bound to the top level.
`timescale 1ns / 1ps
module aga_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  cmd,
  input logic        done,
  input logic        found,
  input logic [7:0]  end_read,
  input logic [9:0]  end_genome,
  input logic [7:0]  start_read,
  input logic [8:0]  match_count,
  input logic [8:0]  mismatch_count,
  input logic [9:0]  insertion_count,
  input logic [8:0]  deletion_count
);
  import aga_pkg::*;

  // a run item makes the block busy at once
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_RUN |=> busy)
    else $error("run item did not raise busy");

  // loads give no result and leave the block free
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd != CMD_RUN |=> !busy && !done)
    else $error("load item caused activity");

  // the result strobe lasts one cycle and then the block is free
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe not a single cycle");

  // a miss carries nothing but the score
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> end_read == 8'd0 && end_genome == 10'd0 && start_read == 8'd0 &&
      match_count == 9'd0 && mismatch_count == 9'd0 && insertion_count == 10'd0 &&
      deletion_count == 9'd0)
    else $error("miss result has non-zero fields");
endmodule

bind affine_gap_local_align_top aga_checker u_aga_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
  .found(found), .end_read(end_read), .end_genome(end_genome), .start_read(start_read),
  .match_count(match_count), .mismatch_count(mismatch_count),
  .insertion_count(insertion_count), .deletion_count(deletion_count)
);
